// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- sv/rtccal_pkg.sv -----
package rtccal_pkg;

	// field widths
	localparam int CFG_W   = 8;
	localparam int SEC_W   = 6;
	localparam int MIN_W   = 6;
	localparam int HOUR_W  = 5;
	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;

	// default divider counter width
	localparam int CNT_W_DEF = 8;

	// register reset values
	localparam logic [CFG_W-1:0] TPS_RST  = 8'd10;
	localparam logic [CFG_W-1:0] SPLP_RST = 8'd10;

	// calendar reset values and limits
	localparam logic [DAY_W-1:0]   DAY_RST   = 5'd1;
	localparam logic [MONTH_W-1:0] MONTH_RST = 4'd1;
	localparam logic [YEAR_W-1:0]  YEAR_RST  = 14'd2000;
	localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
	localparam logic [MONTH_W-1:0] DEC       = 4'd12;
	localparam logic [MONTH_W-1:0] FEB       = 4'd2;

	// y / 100 as (y * 5243) >> 19, exact for y below 43690
	localparam int RECIP_SHIFT = 19;
	localparam logic [12:0] RECIP_100 = 13'd5243;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_TPS     = 2'd0,
		REG_SPLP    = 2'd1,
		REG_RST_REQ = 2'd2,
		REG_CAL_EN  = 2'd3
	} cfg_reg_t;

	// month length; months outside 1..12 count as 31 days
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		case (m)
			4'd2:                      len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

// ----- sv/tick_divider_rtc_calendar.sv -----
// Tick divider with calendar. Each transfer on the input channel is either a
// 100 ms tick (opcode 0) or a calendar load (opcode 1), and yields exactly one
// result: the tick events (second pulse, long-period pulse, watchdog clear) and
// the calendar after the item. One item is accepted every clock cycle while
// in_ready is high; the whole update is one pass of logic from the state
// registers into the output register, so the result appears the cycle after
// the transfer, and input ready stays high unless the output register holds an
// untaken result. The longest path is the leap-year check (one 14x13 multiply)
// into the day and month rollover. Configuration is written through
// cfg_we/cfg_index/cfg_wdata and should only change while the block is idle.
module tick_divider_rtc_calendar #(
	parameter int COUNTER_WIDTH = rtccal_pkg::CNT_W_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_we,
	input  logic [1:0]                        cfg_index,
	input  logic [rtccal_pkg::CFG_W-1:0]      cfg_wdata,
	// input channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              opcode,
	input  logic [rtccal_pkg::SEC_W-1:0]      load_second,
	input  logic [rtccal_pkg::MIN_W-1:0]      load_minute,
	input  logic [rtccal_pkg::HOUR_W-1:0]     load_hour,
	input  logic [rtccal_pkg::DAY_W-1:0]      load_day,
	input  logic [rtccal_pkg::MONTH_W-1:0]    load_month,
	input  logic [rtccal_pkg::YEAR_W-1:0]     load_year,
	// output channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              second_pulse,
	output logic                              long_period_pulse,
	output logic                              watchdog_clear,
	output logic [rtccal_pkg::SEC_W-1:0]      cur_second,
	output logic [rtccal_pkg::MIN_W-1:0]      cur_minute,
	output logic [rtccal_pkg::HOUR_W-1:0]     cur_hour,
	output logic [rtccal_pkg::DAY_W-1:0]      cur_day,
	output logic [rtccal_pkg::MONTH_W-1:0]    cur_month,
	output logic [rtccal_pkg::YEAR_W-1:0]     cur_year
);
	import rtccal_pkg::*;

	`include "assert_macros.svh"

	localparam int CMP_W = (COUNTER_WIDTH + 1 > CFG_W) ? COUNTER_WIDTH + 1 : CFG_W;
	localparam int PROD_W = YEAR_W + 13;

	// configuration registers
	logic [CFG_W-1:0] tps_q, splp_q;
	logic             rst_req_q, cal_en_q;

	// divider and calendar state
	logic [COUNTER_WIDTH-1:0] tick_q, secs_q;
	logic [SEC_W-1:0]   sec_q;
	logic [MIN_W-1:0]   min_q;
	logic [HOUR_W-1:0]  hour_q;
	logic [DAY_W-1:0]   day_q;
	logic [MONTH_W-1:0] month_q;
	logic [YEAR_W-1:0]  year_q;

	// output register
	logic               out_valid_q;
	logic               sp_q, lp_q, wd_q;
	logic [SEC_W-1:0]   osec_q;
	logic [MIN_W-1:0]   omin_q;
	logic [HOUR_W-1:0]  ohour_q;
	logic [DAY_W-1:0]   oday_q;
	logic [MONTH_W-1:0] omonth_q;
	logic [YEAR_W-1:0]  oyear_q;

	// next-state values
	logic                     accept;
	logic [COUNTER_WIDTH:0]   tick_inc, secs_inc;
	logic                     sec_evt, long_evt;
	logic [COUNTER_WIDTH-1:0] tick_n, secs_n;
	logic [SEC_W-1:0]         sec_n;
	logic [MIN_W-1:0]         min_n;
	logic [HOUR_W-1:0]        hour_n;
	logic [DAY_W-1:0]         day_n;
	logic [MONTH_W-1:0]       month_n;
	logic [YEAR_W-1:0]        year_n;
	logic                     sp_n, lp_n, wd_n;
	logic [SEC_W:0]           sec_inc;
	logic [MIN_W:0]           min_inc;
	logic [HOUR_W:0]          hour_inc;
	logic [DAY_W:0]           day_inc;
	logic [PROD_W-1:0]        year_prod;
	logic                     div100, leap;
	logic [DAY_W-1:0]         mlen;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q     <= TPS_RST;
			splp_q    <= SPLP_RST;
			rst_req_q <= 1'b0;
			cal_en_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_TPS:     tps_q     <= cfg_wdata;
				REG_SPLP:    splp_q    <= cfg_wdata;
				REG_RST_REQ: rst_req_q <= cfg_wdata[0];
				REG_CAL_EN:  cal_en_q  <= cfg_wdata[0];
			endcase
		end
	end

	// leap year: y % 100 == 0 when the fraction of y/100 is small
	assign year_prod = PROD_W'(year_q) * PROD_W'(RECIP_100);
	assign div100    = year_prod[RECIP_SHIFT-1:0] < RECIP_SHIFT'(RECIP_100);
	assign leap      = div100 ? (year_prod[RECIP_SHIFT+1:RECIP_SHIFT] == 2'b00)
	                          : (year_q[1:0] == 2'b00);
	assign mlen      = month_len(month_q, leap);

	// divider counters
	assign tick_inc = {1'b0, tick_q} + 1'b1;
	assign secs_inc = {1'b0, secs_q} + 1'b1;
	assign sec_evt  = CMP_W'(tick_inc) >= CMP_W'(tps_q);
	assign long_evt = CMP_W'(secs_inc) >= CMP_W'(splp_q);

	assign sec_inc  = {1'b0, sec_q} + 1'b1;
	assign min_inc  = {1'b0, min_q} + 1'b1;
	assign hour_inc = {1'b0, hour_q} + 1'b1;
	assign day_inc  = {1'b0, day_q} + 1'b1;

	// item update
	always_comb begin
		tick_n  = tick_q;
		secs_n  = secs_q;
		sec_n   = sec_q;
		min_n   = min_q;
		hour_n  = hour_q;
		day_n   = day_q;
		month_n = month_q;
		year_n  = year_q;
		sp_n    = 1'b0;
		lp_n    = 1'b0;
		wd_n    = 1'b0;
		if (opcode) begin
			sec_n   = load_second;
			min_n   = load_minute;
			hour_n  = load_hour;
			day_n   = load_day;
			month_n = load_month;
			year_n  = load_year;
		end else begin
			wd_n   = !rst_req_q;
			tick_n = tick_inc[COUNTER_WIDTH-1:0];
			if (sec_evt) begin
				tick_n = '0;
				sp_n   = 1'b1;
				secs_n = secs_inc[COUNTER_WIDTH-1:0];
				if (long_evt) begin
					secs_n = '0;
					lp_n   = 1'b1;
				end
				// calendar cascade
				if (cal_en_q) begin
					sec_n = sec_inc[SEC_W-1:0];
					if (sec_inc >= (SEC_W+1)'(60)) begin
						sec_n = '0;
						min_n = min_inc[MIN_W-1:0];
						if (min_inc >= (MIN_W+1)'(60)) begin
							min_n  = '0;
							hour_n = hour_inc[HOUR_W-1:0];
							if (hour_inc >= (HOUR_W+1)'(24)) begin
								hour_n = '0;
								day_n  = day_inc[DAY_W-1:0];
								if (day_inc > {1'b0, mlen}) begin
									day_n = DAY_RST;
									if (month_q >= DEC) begin
										month_n = MONTH_RST;
										year_n  = (year_q >= YEAR_MAX) ? '0 : year_q + 1'b1;
									end else begin
										month_n = month_q + 1'b1;
									end
								end
							end
						end
					end
				end
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q  <= '0;
			secs_q  <= '0;
			sec_q   <= '0;
			min_q   <= '0;
			hour_q  <= '0;
			day_q   <= DAY_RST;
			month_q <= MONTH_RST;
			year_q  <= YEAR_RST;
		end else if (accept) begin
			tick_q  <= tick_n;
			secs_q  <= secs_n;
			sec_q   <= sec_n;
			min_q   <= min_n;
			hour_q  <= hour_n;
			day_q   <= day_n;
			month_q <= month_n;
			year_q  <= year_n;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			sp_q     <= sp_n;
			lp_q     <= lp_n;
			wd_q     <= wd_n;
			osec_q   <= sec_n;
			omin_q   <= min_n;
			ohour_q  <= hour_n;
			oday_q   <= day_n;
			omonth_q <= month_n;
			oyear_q  <= year_n;
		end
	end

	assign out_valid         = out_valid_q;
	assign second_pulse      = sp_q;
	assign long_period_pulse = lp_q;
	assign watchdog_clear    = wd_q;
	assign cur_second        = osec_q;
	assign cur_minute        = omin_q;
	assign cur_hour          = ohour_q;
	assign cur_day           = oday_q;
	assign cur_month         = omonth_q;
	assign cur_year          = oyear_q;

	// checks
	`ASSERT_NEXT(a_accept_gives_result, clk, arst_n, accept, out_valid)
	`ASSERT_SAME(a_long_needs_second, clk, arst_n, out_valid && long_period_pulse, second_pulse)
	`ASSERT_NEXT(a_load_sets_calendar, clk, arst_n, accept && opcode,
		cur_year == $past(load_year) && cur_second == $past(load_second) && !second_pulse)
	`ASSERT_NEXT(a_state_matches_out, clk, arst_n, accept,
		sec_q == cur_second && year_q == cur_year && month_q == cur_month)

endmodule

// ----- verif/rtc_calendar_checker.sv -----
package rtc_tb_pkg;

	// item kinds on the input channel
	typedef enum logic {
		OP_TICK = 1'b0,
		OP_LOAD = 1'b1
	} rtc_op_t;

endpackage

module rtc_calendar_checker #(
	parameter int CNT_W = rtccal_pkg::CNT_W_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [1:0]                        cfg_index,
	input  logic [rtccal_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic                              opcode,
	input  logic [rtccal_pkg::SEC_W-1:0]      load_second,
	input  logic [rtccal_pkg::MIN_W-1:0]      load_minute,
	input  logic [rtccal_pkg::HOUR_W-1:0]     load_hour,
	input  logic [rtccal_pkg::DAY_W-1:0]      load_day,
	input  logic [rtccal_pkg::MONTH_W-1:0]    load_month,
	input  logic [rtccal_pkg::YEAR_W-1:0]     load_year,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic                              second_pulse,
	input  logic                              long_period_pulse,
	input  logic                              watchdog_clear,
	input  logic [rtccal_pkg::SEC_W-1:0]      cur_second,
	input  logic [rtccal_pkg::MIN_W-1:0]      cur_minute,
	input  logic [rtccal_pkg::HOUR_W-1:0]     cur_hour,
	input  logic [rtccal_pkg::DAY_W-1:0]      cur_day,
	input  logic [rtccal_pkg::MONTH_W-1:0]    cur_month,
	input  logic [rtccal_pkg::YEAR_W-1:0]     cur_year,
	output int                                fail_count,
	output int                                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import rtccal_pkg::*;
	import rtc_tb_pkg::*;

	typedef struct {
		logic               sp;
		logic               lp;
		logic               wd;
		logic [SEC_W-1:0]   sec;
		logic [MIN_W-1:0]   min;
		logic [HOUR_W-1:0]  hour;
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
	} rtc_result_t;

	rtc_result_t expected_results[$];
	int err_count = 0;

	// shadow configuration
	logic [CFG_W-1:0] tps_q;
	logic [CFG_W-1:0] splp_q;
	logic             rst_req_q;
	logic             cal_en_q;

	// shadow divider and calendar
	logic [CNT_W-1:0]   tick_cnt;
	logic [CNT_W-1:0]   sec_cnt;
	logic [SEC_W-1:0]   cal_sec;
	logic [MIN_W-1:0]   cal_min;
	logic [HOUR_W-1:0]  cal_hour;
	logic [DAY_W-1:0]   cal_day;
	logic [MONTH_W-1:0] cal_month;
	logic [YEAR_W-1:0]  cal_year;

	assign fail_count = err_count;

	function automatic bit is_leap(int unsigned y);
		return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
	endfunction

	// months outside 1..12 are 31 days long
	function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
		case (m)
			2:           return is_leap(y) ? 29 : 28;
			4, 6, 9, 11: return 30;
			default:     return 31;
		endcase
	endfunction

	task automatic advance_day();
		int unsigned d;
		d = cal_day + 1;
		if (d > days_in_month(cal_month, cal_year)) begin
			d = 1;
			if (cal_month >= DEC) begin
				cal_month = MONTH_RST;
				cal_year = (cal_year >= YEAR_MAX) ? '0 : YEAR_W'(cal_year + 1);
			end else begin
				cal_month = MONTH_W'(cal_month + 1);
			end
		end
		cal_day = DAY_W'(d);
	endtask

	// out-of-range values roll over on their next increment
	task automatic advance_second();
		int unsigned v;
		v = cal_sec + 1;
		if (v < 60) begin
			cal_sec = SEC_W'(v);
			return;
		end
		cal_sec = '0;
		v = cal_min + 1;
		if (v < 60) begin
			cal_min = MIN_W'(v);
			return;
		end
		cal_min = '0;
		v = cal_hour + 1;
		if (v < 24) begin
			cal_hour = HOUR_W'(v);
			return;
		end
		cal_hour = '0;
		advance_day();
	endtask

	// next result for the item on the input port
	task automatic predict_item(output rtc_result_t r);
		int unsigned t;
		r.sp = 1'b0;
		r.lp = 1'b0;
		r.wd = 1'b0;
		if (opcode == OP_LOAD) begin
			cal_sec   = load_second;
			cal_min   = load_minute;
			cal_hour  = load_hour;
			cal_day   = load_day;
			cal_month = load_month;
			cal_year  = load_year;
		end else begin
			// compare before truncation; a zero period fires every time
			t = tick_cnt + 1;
			tick_cnt = CNT_W'(t);
			if (t >= tps_q) begin
				tick_cnt = '0;
				r.sp = 1'b1;
				if (cal_en_q)
					advance_second();
				t = sec_cnt + 1;
				sec_cnt = CNT_W'(t);
				if (t >= splp_q) begin
					sec_cnt = '0;
					r.lp = 1'b1;
				end
			end
			r.wd = !rst_req_q;
		end
		r.sec   = cal_sec;
		r.min   = cal_min;
		r.hour  = cal_hour;
		r.day   = cal_day;
		r.month = cal_month;
		r.year  = cal_year;
	endtask

	function automatic void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			err_count++;
		end
	endfunction

	// config writes, then result transfers against the oldest expectation,
	// then predictions for input transfers
	always @(posedge clk or negedge arst_n) begin : monitor
		rtc_result_t want;
		rtc_result_t next_res;
		if (!arst_n) begin
			tps_q     = TPS_RST;
			splp_q    = SPLP_RST;
			rst_req_q = 1'b0;
			cal_en_q  = 1'b0;
			tick_cnt  = '0;
			sec_cnt   = '0;
			cal_sec   = '0;
			cal_min   = '0;
			cal_hour  = '0;
			cal_day   = DAY_RST;
			cal_month = MONTH_RST;
			cal_year  = YEAR_RST;
			expected_results.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TPS:     tps_q = cfg_wdata;
					REG_SPLP:    splp_q = cfg_wdata;
					REG_RST_REQ: rst_req_q = cfg_wdata[0];
					REG_CAL_EN:  cal_en_q = cfg_wdata[0];
					default:     ;
				endcase
			end

			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with no expectation pending");
					err_count++;
				end else begin
					want = expected_results.pop_front();
					compare_field("second_pulse", want.sp, second_pulse);
					compare_field("long_period_pulse", want.lp, long_period_pulse);
					compare_field("watchdog_clear", want.wd, watchdog_clear);
					compare_field("cur_second", want.sec, cur_second);
					compare_field("cur_minute", want.min, cur_minute);
					compare_field("cur_hour", want.hour, cur_hour);
					compare_field("cur_day", want.day, cur_day);
					compare_field("cur_month", want.month, cur_month);
					compare_field("cur_year", want.year, cur_year);
				end
			end

			if (in_valid && in_ready) begin
				predict_item(next_res);
				expected_results.push_back(next_res);
			end

			pending <= expected_results.size();
		end
	end

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rtccal_pkg::*;
	import rtc_tb_pkg::*;

	localparam int TIMEOUT_CYCLES = 400000;
	localparam int LONG_HOLD      = 200;
	localparam int DRAIN_CYCLES   = 10;
	localparam int NUM_PHASES     = 7;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_index = REG_TPS;
	logic [CFG_W-1:0]   cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               opcode = OP_TICK;
	logic [SEC_W-1:0]   load_second = '0;
	logic [MIN_W-1:0]   load_minute = '0;
	logic [HOUR_W-1:0]  load_hour = '0;
	logic [DAY_W-1:0]   load_day = '0;
	logic [MONTH_W-1:0] load_month = '0;
	logic [YEAR_W-1:0]  load_year = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               second_pulse;
	logic               long_period_pulse;
	logic               watchdog_clear;
	logic [SEC_W-1:0]   cur_second;
	logic [MIN_W-1:0]   cur_minute;
	logic [HOUR_W-1:0]  cur_hour;
	logic [DAY_W-1:0]   cur_day;
	logic [MONTH_W-1:0] cur_month;
	logic [YEAR_W-1:0]  cur_year;

	int fail_count;
	int pending;

	int hold_reqs = 0;
	int hold_served = 0;
	bit no_idle = 1'b0;
	int items_sent = 0;
	int cycle_cnt = 0;
	logic [CFG_W-1:0] cur_tps = TPS_RST;

	always #5 clk = ~clk;

	tick_divider_rtc_calendar dut (.*);

	rtc_calendar_checker u_checker (.*);

	// mostly short gaps, a few long ones
	function automatic int idle_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// offer one item and hold it until the transfer
	task automatic send_item(input rtc_op_t op, input logic [SEC_W-1:0] s,
			input logic [MIN_W-1:0] m, input logic [HOUR_W-1:0] h,
			input logic [DAY_W-1:0] d, input logic [MONTH_W-1:0] mo,
			input logic [YEAR_W-1:0] y);
		int gap;
		gap = no_idle ? 0 : idle_cycles();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		load_second <= s;
		load_minute <= m;
		load_hour   <= h;
		load_day    <= d;
		load_month  <= mo;
		load_year   <= y;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// load fields carry noise on ticks
	task automatic send_tick();
		send_item(OP_TICK, SEC_W'($urandom), MIN_W'($urandom), HOUR_W'($urandom),
			DAY_W'($urandom), MONTH_W'($urandom), YEAR_W'($urandom));
	endtask

	task automatic send_load(input logic [SEC_W-1:0] s, input logic [MIN_W-1:0] m,
			input logic [HOUR_W-1:0] h, input logic [DAY_W-1:0] d,
			input logic [MONTH_W-1:0] mo, input logic [YEAR_W-1:0] y);
		send_item(OP_LOAD, s, m, h, d, mo, y);
	endtask

	// calendar set just short of a rollover: end of day, month, year
	task automatic send_edge_load();
		logic [YEAR_W-1:0]  y;
		logic [MONTH_W-1:0] mo;
		logic [DAY_W-1:0]   d;
		case ($urandom_range(0, 7))
			0:       y = 14'd1900;
			1:       y = 14'd2000;
			2:       y = 14'd2100;
			3:       y = 14'd2024;
			4:       y = 14'd2023;
			5:       y = YEAR_MAX;
			6:       y = YEAR_W'($urandom_range(0, 9999));
			default: y = YEAR_W'($urandom_range(10000, 16383));
		endcase
		case ($urandom_range(0, 9))
			0:       mo = MONTH_W'($urandom_range(13, 15));
			1:       mo = '0;
			2, 3:    mo = DEC;
			4, 5:    mo = FEB;
			default: mo = MONTH_W'($urandom_range(1, 12));
		endcase
		d = ($urandom_range(0, 4) != 0) ? DAY_W'($urandom_range(27, 31))
			: DAY_W'($urandom_range(0, 31));
		send_load(($urandom_range(0, 5) != 0) ? 6'd59 : SEC_W'($urandom_range(0, 63)),
			($urandom_range(0, 5) != 0) ? 6'd59 : MIN_W'($urandom_range(0, 63)),
			($urandom_range(0, 4) != 0) ? 5'd23 : HOUR_W'($urandom_range(0, 31)),
			d, mo, y);
	endtask

	// stop offering and wait for every outstanding result
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// write all four registers on back-to-back cycles
	task automatic apply_config(input logic [CFG_W-1:0] tps, input logic [CFG_W-1:0] splp,
			input logic rst_req, input logic cal_en);
		cfg_we    <= 1'b1;
		cfg_index <= REG_TPS;
		cfg_wdata <= tps;
		@(posedge clk);
		cfg_index <= REG_SPLP;
		cfg_wdata <= splp;
		@(posedge clk);
		cfg_index <= REG_RST_REQ;
		cfg_wdata <= {7'($urandom), rst_req};
		@(posedge clk);
		cfg_index <= REG_CAL_EN;
		cfg_wdata <= {7'($urandom), cal_en};
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_tps = tps;
	endtask

	// output side: random ready with idle gaps, long hold-off on request
	initial begin : receiver
		int n;
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_reqs != hold_served) begin
				hold_served++;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				n = no_idle ? 0 : idle_cycles();
				if (n > 0) begin
					out_ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// run limit
	initial begin : watchdog
		while (cycle_cnt < TIMEOUT_CYCLES) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		logic [CFG_W-1:0] tps;
		logic [CFG_W-1:0] splp;
		logic             rst_req;
		logic             cal_en;
		int               target;
		int               phase_start;
		int               r;
		int               k;
		bit               paused;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, calendar off: second pulse on the tenth tick
		repeat (11) send_tick();
		wait_drained();

		// one tick per second: day, leap-day, century and year rollovers
		apply_config(8'd1, 8'd2, 1'b0, 1'b1);
		send_load(6'd59, 6'd59, 5'd23, 5'd31, DEC, YEAR_MAX);
		send_tick();
		send_load(6'd59, 6'd59, 5'd23, 5'd28, FEB, 14'd2000);
		send_tick();
		send_load(6'd59, 6'd59, 5'd23, 5'd28, FEB, 14'd1900);
		send_tick();
		send_load(6'd59, 6'd59, 5'd23, 5'd29, FEB, 14'd2024);
		send_tick();
		// all-ones and all-zeros loads: the out-of-range all-ones fields roll over
		send_load('1, '1, '1, '1, '1, '1);
		send_tick();
		send_load('0, '0, '0, '0, '0, '0);
		send_tick();
		wait_drained();

		// zero periods fire every time; reset request blocks the watchdog clear
		apply_config(8'd0, 8'd0, 1'b1, 1'b1);
		send_tick();
		send_tick();

		// random phases, each under its own settings
		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_drained();
			target = 130;
			case (p)
				0: begin
					tps = 8'd1; splp = 8'd1; rst_req = 1'b0; cal_en = 1'b1;
				end
				1: begin
					tps = 8'd2; splp = 8'd3; rst_req = 1'b1; cal_en = 1'b1;
				end
				2: begin
					tps = CFG_W'($urandom_range(1, 5));
					splp = CFG_W'($urandom_range(1, 5));
					rst_req = 1'($urandom);
					cal_en = 1'b0;
				end
				3: begin
					tps = 8'd0; splp = 8'd0; rst_req = 1'b0; cal_en = 1'b1;
				end
				4: begin
					tps = 8'd255; splp = 8'd255; rst_req = 1'($urandom); cal_en = 1'b1;
					target = 300;
				end
				5: begin
					tps = 8'd1; splp = CFG_W'($urandom_range(1, 255));
					rst_req = 1'($urandom); cal_en = 1'b1;
				end
				default: begin
					tps = TPS_RST; splp = SPLP_RST; rst_req = 1'b0; cal_en = 1'b1;
				end
			endcase
			apply_config(tps, splp, rst_req, cal_en);

			// back-pressure: output held off while input keeps coming
			if (p == 1) begin
				hold_reqs++;
				no_idle = 1'b1;
			end

			phase_start = items_sent;
			paused = 1'b0;
			while (items_sent - phase_start < target) begin
				if (p == 1 && items_sent - phase_start >= 50)
					no_idle = 1'b0;
				if (p == 2 && !paused && items_sent - phase_start >= 60) begin
					wait_drained();
					paused = 1'b1;
				end

				r = $urandom_range(0, 99);
				if (cur_tps > 8'd6)
					r = (r < 90) ? 99 : r;
				if (r < 70) begin
					send_edge_load();
					k = (cur_tps >= 8'd1 && cur_tps <= 8'd6)
						? $urandom_range(1, 2 * cur_tps + 1) : $urandom_range(1, 4);
					repeat (k) send_tick();
				end else if (r < 85) begin
					send_load(SEC_W'($urandom), MIN_W'($urandom), HOUR_W'($urandom),
						DAY_W'($urandom), MONTH_W'($urandom), YEAR_W'($urandom));
				end else begin
					repeat ($urandom_range(1, 40)) send_tick();
				end
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+sv
sv/rtccal_pkg.sv
sv/tick_divider_rtc_calendar.sv
verif/rtc_calendar_checker.sv
verif/tb_top.sv
